@@ rtl/ihtq_pkg.sv @@
`default_nettype none

package ihtq_pkg;

    // Field widths fixed by the interface
    localparam int TIME_W       = 48;
    localparam int PER_W        = 32;
    localparam int ID_OUT_W     = 5;
    localparam int DEF_CAPACITY = 32;

    // Request codes
    typedef enum logic [1:0] {
        MODE_REGISTER = 2'd0,
        MODE_CANCEL   = 2'd1,
        MODE_POLL     = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    // Result codes
    typedef enum logic [1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_REJECTED   = 2'd1,
        KIND_EXPIRED    = 2'd2
    } kind_t;

    // Access strobes from the sequencer to every level cell
    typedef struct packed {
        logic rd_a;
        logic rd_b;
        logic wr;
    } heap_en_t;

endpackage

`default_nettype wire

@@ rtl/ihtq_level_cell.sv @@
`default_nettype none

// One heap level: positions 2^LVL-1 .. 2^(LVL+1)-2, clipped to the capacity.
// Each cell decodes the shared position buses and answers only for its own
// level, so a sift walks from cell to neighbor cell one level per step.
module ihtq_level_cell #(
    parameter int CAPACITY = ihtq_pkg::DEF_CAPACITY,
    parameter int LVL      = 0,
    parameter int AW       = 7,
    parameter int EW       = 85
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ihtq_pkg::heap_en_t en,
    input  wire logic [AW-1:0]      rd_a_pos,
    input  wire logic [AW-1:0]      rd_b_pos,
    input  wire logic [AW-1:0]      wr_pos,
    input  wire logic [EW-1:0]      wr_data,
    output logic      [EW-1:0]      rd_a_data,
    output logic      [EW-1:0]      rd_b_data
);

    localparam int BASE  = 1 << LVL;
    localparam int DEPTH = (CAPACITY - BASE + 1 < BASE) ? (CAPACITY - BASE + 1) : BASE;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0] a1, b1, w1;
    logic          a_hit, b_hit, w_hit;
    logic [IW-1:0] a_idx, b_idx, w_idx;

    logic [EW-1:0] mem_reg [DEPTH];
    logic [EW-1:0] a_data_reg, b_data_reg;
    logic          a_hit_reg, b_hit_reg;

    // Position decode: level is set by the leading one of pos+1
    assign a1    = rd_a_pos + AW'(1);
    assign b1    = rd_b_pos + AW'(1);
    assign w1    = wr_pos + AW'(1);
    assign a_hit = (a1 >= AW'(BASE)) && (a1 < AW'(BASE + DEPTH));
    assign b_hit = (b1 >= AW'(BASE)) && (b1 < AW'(BASE + DEPTH));
    assign w_hit = (w1 >= AW'(BASE)) && (w1 < AW'(BASE + DEPTH));
    assign a_idx = IW'(a1 - AW'(BASE));
    assign b_idx = IW'(b1 - AW'(BASE));
    assign w_idx = IW'(w1 - AW'(BASE));

    // Level storage: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (en.wr && w_hit)
        begin
            mem_reg[w_idx] <= wr_data;
        end
        if (en.rd_a && a_hit)
        begin
            a_data_reg <= mem_reg[a_idx];
        end
        if (en.rd_b && b_hit)
        begin
            b_data_reg <= mem_reg[b_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hit_reg <= 1'b0;
            b_hit_reg <= 1'b0;
        end
        else
        begin
            a_hit_reg <= en.rd_a && a_hit;
            b_hit_reg <= en.rd_b && b_hit;
        end
    end

    // Only the owning level drives nonzero data onto the OR bus
    assign rd_a_data = a_hit_reg ? a_data_reg : '0;
    assign rd_b_data = b_hit_reg ? b_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/ihtq_id_table.sv @@
`default_nettype none

// Per-id word: heap position of a live id, or next free id of a free one.
// Entries never written read as id+1, which is the free chain after reset.
module ihtq_id_table #(
    parameter int CAPACITY = ihtq_pkg::DEF_CAPACITY,
    parameter int IDW      = 5,
    parameter int PW       = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rd_en,
    input  wire logic [IDW-1:0] rd_idx,
    output logic      [PW-1:0]  rd_data,
    input  wire logic           wr_en,
    input  wire logic [IDW-1:0] wr_idx,
    input  wire logic [PW-1:0]  wr_data
);

    logic [PW-1:0]       mem_reg [CAPACITY];
    logic [CAPACITY-1:0] written_reg;
    logic [PW-1:0]       rd_q_reg;
    logic [IDW-1:0]      rd_idx_reg;
    logic                rd_written_reg;

    // Storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg   <= mem_reg[rd_idx];
            rd_idx_reg <= rd_idx;
        end
    end

    // Written flags stand in for the reset chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_idx] || (wr_en && wr_idx == rd_idx);
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_q_reg : PW'(rd_idx_reg) + PW'(1);

endmodule

`default_nettype wire

@@ rtl/indexed_heap_timer_queue_top.sv @@
`default_nettype none

// Periodic timer queue on a binary min-heap ordered by expiry.
// Input channel (in_valid/in_ready) takes one request beat: mode 0 registers
// a timer (interval_us, delay_us), mode 1 cancels cancel_id, mode 2 polls at
// now_us, mode 3 does nothing. Output channel (out_valid/out_ready) returns
// result beats: one per register request, none for cancel, one per expired
// timer for a poll with last set on the final beat.
// The heap lives in a chain of level cells; a sift moves one level per step
// (read, then compare and write). A rejected register and a cancel of an id
// that is not live touch no heap cell. A poll handles each expired timer by
// root removal sift down, re-arm sift up, root check and result beat.
// One request is worked at a time; in_ready is high only when idle.
// A finished result sits in the output register; the next request is taken
// while it waits. A poll with more expired timers stalls when the output
// register is still full and out_ready is low.
// Reset empties the queue and rebuilds the id free list at once; no
// clearing pass is needed.
module indexed_heap_timer_queue_top #(
    parameter int CAPACITY = ihtq_pkg::DEF_CAPACITY
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [47:0] now_us,
    input  wire logic [31:0] interval_us,
    input  wire logic [31:0] delay_us,
    input  wire logic [4:0]  cancel_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [4:0]       tmr_id,
    output logic [47:0]      expiry_us,
    output logic             last
);

    localparam int TW   = ihtq_pkg::TIME_W;
    localparam int PRW  = ihtq_pkg::PER_W;
    localparam int OW   = ihtq_pkg::ID_OUT_W;
    localparam int IDW  = $clog2(CAPACITY);
    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int AW   = PW + 1;
    localparam int NLVL = $clog2(CAPACITY + 1);
    localparam int EW   = TW + PRW + IDW;

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_ID_RD  = 14'h0002,
        S_RM_RD  = 14'h0004,
        S_RM_A   = 14'h0008,
        S_RM_B   = 14'h0010,
        S_SU_RD  = 14'h0020,
        S_SU_CMP = 14'h0040,
        S_SD_RD  = 14'h0080,
        S_SD_CMP = 14'h0100,
        S_DONE   = 14'h0200,
        S_PL_RD  = 14'h0400,
        S_PL_CHK = 14'h0800,
        S_FIRE   = 14'h1000,
        S_EMIT   = 14'h2000
    } state_t;

    state_t              state_reg, state_next;
    ihtq_pkg::mode_t     op_reg, op_next;
    logic [TW-1:0]       now_reg, now_next;
    logic [PRW-1:0]      interval_reg, interval_next;
    logic [PRW-1:0]      delay_reg, delay_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [EW-1:0]       x_reg, x_next;
    logic [PW-1:0]       lc_reg, lc_next;
    logic [PW-1:0]       free_top_reg, free_top_next;
    logic [CAPACITY-1:0] live_reg, live_next;
    logic [PW-1:0]       budget_reg, budget_next;
    logic                ins_phase_reg, ins_phase_next;
    logic                have_pend_reg, have_pend_next;
    logic                more_reg, more_next;
    ihtq_pkg::kind_t     res_kind_reg, res_kind_next;
    logic [IDW-1:0]      res_id_reg, res_id_next;
    logic [TW-1:0]       res_exp_reg, res_exp_next;
    logic                res_last_reg, res_last_next;
    logic [TW-1:0]       fire_e_reg, fire_e_next;
    logic [PRW-1:0]      fire_p_reg, fire_p_next;
    logic [IDW-1:0]      fire_o_reg, fire_o_next;
    logic                out_valid_reg, out_valid_next;
    ihtq_pkg::kind_t     out_kind_reg, out_kind_next;
    logic [OW-1:0]       out_id_reg, out_id_next;
    logic [TW-1:0]       out_exp_reg, out_exp_next;
    logic                out_last_reg, out_last_next;

    // Heap cell bus
    ihtq_pkg::heap_en_t hp_en;
    logic [AW-1:0]      hp_a_pos, hp_b_pos, hp_w_pos;
    logic [EW-1:0]      hp_w_data;
    logic [EW-1:0]      cell_a [NLVL];
    logic [EW-1:0]      cell_b [NLVL];
    logic [EW-1:0]      rd_a, rd_b;

    // Id table port
    logic           it_rd_en, it_wr_en;
    logic [IDW-1:0] it_rd_idx, it_wr_idx;
    logic [PW-1:0]  it_rd_data, it_wr_data;

    logic [TW-1:0]  ra_e, rb_e, x_e;
    logic [PRW-1:0] ra_p;
    logic [IDW-1:0] ra_o, x_o;
    logic [PW-1:0]  par_pos;
    logic [AW-1:0]  left_pos, child2_pos, lc_a;
    logic [PRW-1:0] add_b;
    logic [TW:0]    sum;
    logic [TW-1:0]  sat_time;
    logic           out_free;
    logic           take_b;
    logic [EW-1:0]  c_ent;
    logic [AW-1:0]  c_pos;

    // Level cells
    for (genvar lv = 0; lv < NLVL; lv++)
    begin : g_lvl
        ihtq_level_cell #(
            .CAPACITY (CAPACITY),
            .LVL      (lv),
            .AW       (AW),
            .EW       (EW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (hp_en),
            .rd_a_pos  (hp_a_pos),
            .rd_b_pos  (hp_b_pos),
            .wr_pos    (hp_w_pos),
            .wr_data   (hp_w_data),
            .rd_a_data (cell_a[lv]),
            .rd_b_data (cell_b[lv])
        );
    end

    ihtq_id_table #(
        .CAPACITY (CAPACITY),
        .IDW      (IDW),
        .PW       (PW)
    ) u_id_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (it_rd_en),
        .rd_idx  (it_rd_idx),
        .rd_data (it_rd_data),
        .wr_en   (it_wr_en),
        .wr_idx  (it_wr_idx),
        .wr_data (it_wr_data)
    );

    // OR the level outputs; only one level answers a read
    always_comb
    begin
        rd_a = '0;
        rd_b = '0;
        for (int i = 0; i < NLVL; i++)
        begin
            rd_a = rd_a | cell_a[i];
            rd_b = rd_b | cell_b[i];
        end
    end

    // Entry layout: {expiry, period, owner}
    assign ra_e = rd_a[EW-1 -: TW];
    assign ra_p = rd_a[IDW +: PRW];
    assign ra_o = rd_a[IDW-1:0];
    assign rb_e = rd_b[EW-1 -: TW];
    assign x_e  = x_reg[EW-1 -: TW];
    assign x_o  = x_reg[IDW-1:0];

    // Tree neighbors of the current position
    assign par_pos    = (pos_reg - PW'(1)) >> 1;
    assign left_pos   = (AW'(pos_reg) << 1) + AW'(1);
    assign child2_pos = left_pos + AW'(1);
    assign lc_a       = AW'(lc_reg);

    // Saturating expiry: now plus delay (register) or period (re-arm)
    assign add_b    = (op_reg == ihtq_pkg::MODE_REGISTER) ? delay_reg : fire_p_reg;
    assign sum      = {1'b0, now_reg} + (TW + 1)'(add_b);
    assign sat_time = sum[TW] ? '1 : sum[TW-1:0];

    // Sift down child pick: right child when it exists and left >= right
    assign take_b = (child2_pos < lc_a) && (ra_e >= rb_e);
    assign c_ent  = take_b ? rd_b : rd_a;
    assign c_pos  = take_b ? child2_pos : left_pos;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        interval_next  = interval_reg;
        delay_next     = delay_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        lc_next        = lc_reg;
        free_top_next  = free_top_reg;
        live_next      = live_reg;
        budget_next    = budget_reg;
        ins_phase_next = ins_phase_reg;
        have_pend_next = have_pend_reg;
        more_next      = more_reg;
        res_kind_next  = res_kind_reg;
        res_id_next    = res_id_reg;
        res_exp_next   = res_exp_reg;
        res_last_next  = res_last_reg;
        fire_e_next    = fire_e_reg;
        fire_p_next    = fire_p_reg;
        fire_o_next    = fire_o_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_exp_next   = out_exp_reg;
        out_last_next  = out_last_reg;

        hp_en      = '0;
        hp_a_pos   = '0;
        hp_b_pos   = '0;
        hp_w_pos   = AW'(pos_reg);
        hp_w_data  = x_reg;
        it_rd_en   = 1'b0;
        it_rd_idx  = '0;
        it_wr_en   = 1'b0;
        it_wr_idx  = x_o;
        it_wr_data = pos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = ihtq_pkg::mode_t'(mode);
                    now_next      = now_us;
                    interval_next = interval_us;
                    delay_next    = delay_us;
                    case (mode)
                        ihtq_pkg::MODE_REGISTER:
                        begin
                            if (interval_us == '0 || lc_reg == PW'(CAPACITY))
                            begin
                                res_kind_next = ihtq_pkg::KIND_REJECTED;
                                res_id_next   = '0;
                                res_exp_next  = '0;
                                res_last_next = 1'b1;
                                more_next     = 1'b0;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                it_rd_en   = 1'b1;
                                it_rd_idx  = IDW'(free_top_reg);
                                state_next = S_ID_RD;
                            end
                        end
                        ihtq_pkg::MODE_CANCEL:
                        begin
                            if (32'(cancel_id) < CAPACITY && live_reg[IDW'(cancel_id)])
                            begin
                                it_rd_en   = 1'b1;
                                it_rd_idx  = IDW'(cancel_id);
                                state_next = S_ID_RD;
                            end
                        end
                        ihtq_pkg::MODE_POLL:
                        begin
                            budget_next    = lc_reg;
                            have_pend_next = 1'b0;
                            state_next     = S_PL_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Free list pop (register) or position lookup (cancel)
            S_ID_RD:
            begin
                if (op_reg == ihtq_pkg::MODE_REGISTER)
                begin
                    free_top_next = it_rd_data;
                    live_next[IDW'(free_top_reg)] = 1'b1;
                    x_next        = {sat_time, interval_reg, IDW'(free_top_reg)};
                    pos_next      = lc_reg;
                    lc_next       = lc_reg + PW'(1);
                    res_kind_next = ihtq_pkg::KIND_REGISTERED;
                    res_id_next   = IDW'(free_top_reg);
                    res_exp_next  = sat_time;
                    res_last_next = 1'b1;
                    more_next     = 1'b0;
                    state_next    = S_SU_RD;
                end
                else
                begin
                    pos_next   = it_rd_data;
                    state_next = S_RM_RD;
                end
            end

            // Removal: fetch the victim and the last entry
            S_RM_RD:
            begin
                hp_en.rd_a = 1'b1;
                hp_en.rd_b = 1'b1;
                hp_a_pos   = AW'(pos_reg);
                hp_b_pos   = AW'(lc_reg - PW'(1));
                state_next = S_RM_A;
            end

            S_RM_A:
            begin
                lc_next = lc_reg - PW'(1);
                x_next  = rd_b;
                if (op_reg == ihtq_pkg::MODE_CANCEL)
                begin
                    live_next[ra_o] = 1'b0;
                    it_wr_en        = 1'b1;
                    it_wr_idx       = ra_o;
                    it_wr_data      = free_top_reg;
                    free_top_next   = PW'(ra_o);
                end
                if (pos_reg < lc_reg - PW'(1))
                begin
                    if (pos_reg == '0)
                    begin
                        state_next = S_SD_RD;
                    end
                    else
                    begin
                        hp_en.rd_a = 1'b1;
                        hp_a_pos   = AW'(par_pos);
                        state_next = S_RM_B;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Moved entry goes down unless it is below its new parent
            S_RM_B:
            begin
                state_next = (x_e >= ra_e) ? S_SD_RD : S_SU_RD;
            end

            S_SU_RD:
            begin
                if (pos_reg == '0)
                begin
                    hp_en.wr   = 1'b1;
                    it_wr_en   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    hp_en.rd_a = 1'b1;
                    hp_a_pos   = AW'(par_pos);
                    state_next = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                hp_en.wr = 1'b1;
                it_wr_en = 1'b1;
                if (x_e < ra_e)
                begin
                    hp_w_data  = rd_a;
                    it_wr_idx  = ra_o;
                    pos_next   = par_pos;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SD_RD:
            begin
                if (left_pos < lc_a)
                begin
                    hp_en.rd_a = 1'b1;
                    hp_en.rd_b = 1'b1;
                    hp_a_pos   = left_pos;
                    hp_b_pos   = child2_pos;
                    state_next = S_SD_CMP;
                end
                else
                begin
                    hp_en.wr   = 1'b1;
                    it_wr_en   = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SD_CMP:
            begin
                hp_en.wr = 1'b1;
                it_wr_en = 1'b1;
                if (x_e >= c_ent[EW-1 -: TW])
                begin
                    hp_w_data  = c_ent;
                    it_wr_idx  = c_ent[IDW-1:0];
                    pos_next   = PW'(c_pos);
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Continue after a heap operation
            S_DONE:
            begin
                case (op_reg)
                    ihtq_pkg::MODE_REGISTER:
                    begin
                        state_next = S_EMIT;
                    end
                    ihtq_pkg::MODE_POLL:
                    begin
                        if (!ins_phase_reg)
                        begin
                            x_next         = {sat_time, fire_p_reg, fire_o_reg};
                            pos_next       = lc_reg;
                            lc_next        = lc_reg + PW'(1);
                            ins_phase_next = 1'b1;
                            state_next     = S_SU_RD;
                        end
                        else
                        begin
                            state_next = S_PL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Poll: look at the root while budget remains
            S_PL_RD:
            begin
                if (budget_reg != '0 && lc_reg != '0)
                begin
                    hp_en.rd_a = 1'b1;
                    hp_a_pos   = '0;
                    state_next = S_PL_CHK;
                end
                else if (have_pend_reg)
                begin
                    res_last_next = 1'b1;
                    more_next     = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_PL_CHK:
            begin
                if (ra_e <= now_reg)
                begin
                    fire_e_next = ra_e;
                    fire_p_next = ra_p;
                    fire_o_next = ra_o;
                    budget_next = budget_reg - PW'(1);
                    if (have_pend_reg)
                    begin
                        res_last_next = 1'b0;
                        more_next     = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FIRE;
                    end
                end
                else if (have_pend_reg)
                begin
                    res_last_next = 1'b1;
                    more_next     = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Fired timer becomes the pending beat; pull it off the root
            S_FIRE:
            begin
                res_kind_next  = ihtq_pkg::KIND_EXPIRED;
                res_id_next    = fire_o_reg;
                res_exp_next   = fire_e_reg;
                have_pend_next = 1'b1;
                pos_next       = '0;
                ins_phase_next = 1'b0;
                state_next     = S_RM_RD;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_id_next    = OW'(res_id_reg);
                    out_exp_next   = res_exp_reg;
                    out_last_next  = res_last_reg;
                    state_next     = more_reg ? S_FIRE : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            free_top_reg  <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lc_reg        <= lc_next;
            free_top_reg  <= free_top_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        interval_reg  <= interval_next;
        delay_reg     <= delay_next;
        pos_reg       <= pos_next;
        x_reg         <= x_next;
        budget_reg    <= budget_next;
        ins_phase_reg <= ins_phase_next;
        have_pend_reg <= have_pend_next;
        more_reg      <= more_next;
        res_kind_reg  <= res_kind_next;
        res_id_reg    <= res_id_next;
        res_exp_reg   <= res_exp_next;
        res_last_reg  <= res_last_next;
        fire_e_reg    <= fire_e_next;
        fire_p_reg    <= fire_p_next;
        fire_o_reg    <= fire_o_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign tmr_id    = out_id_reg;
    assign expiry_us = out_exp_reg;
    assign last      = out_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= PW'(CAPACITY))
        else $error("live count above capacity");

    a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && lc_reg < PW'(CAPACITY)) |-> (free_top_reg < PW'(CAPACITY)))
        else $error("free list empty while heap not full");

    a_live_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(live_reg) == 32'(lc_reg)))
        else $error("live flags disagree with live count");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !out_ready) |=> (state_reg == S_EMIT))
        else $error("result left the emit state while output was full");

endmodule

`default_nettype wire
